// ----- rtl/kls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kls_pkg
// Types, codes and constants shared by the keyed latency statistics block.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [15:0] PERIOD_RESET = 16'd1024;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_RECORDED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_DONE   = 2'd0,
        K_SAMPLE = 2'd1,
        K_QUERY  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] id;
        logic [31:0] len;
    } t_cmd;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] count;
        logic [47:0] mean;
        logic [63:0] m2;
        logic [31:0] min;
        logic [31:0] max;
    } t_entry;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MOD,
        B_RD,
        B_CHK,
        B_UPD,
        B_MEAN,
        B_MUL,
        B_WR,
        B_VAR,
        B_OUT
    } t_bstate;

endpackage
`default_nettype wire

// ----- rtl/kls_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kls_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module kls_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic [31:0] r_rem;
    logic [63:0] r_quot;
    logic [31:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {r_rem, r_quot[63]};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 7'd64;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= 32'd0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_cnt != 7'd0) begin
            r_rem  <= fits ? 32'(shifted - {1'b0, r_div}) : shifted[31:0];
            r_quot <= {r_quot[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- rtl/kls_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kls_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module kls_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire kls_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output kls_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PTR_W = $clog2(kls_pkg::FIFO_DEPTH);

    kls_pkg::t_cmd    r_buf [kls_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_buf[r_rd];
    assign o_full  = r_cnt == (PTR_W+1)'(kls_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;

endmodule
`default_nettype wire

// ----- rtl/kls_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kls_front
// Accepts input words, keeps the start time and sampling phase, and turns
// each word into a command for the back.
// ----------------------------------------------------------------------------
module kls_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_block_id,
    input  wire logic [47:0] i_time_now,
    input  wire logic        i_sample_valid,
    output kls_pkg::t_cmd    o_cmd
);

    logic [15:0] r_period;
    logic [47:0] r_start;
    logic [15:0] r_phase;
    logic [47:0] diff;
    logic [31:0] len;
    logic [15:0] phase_inc;
    logic [15:0] period;
    logic        sampled;
    logic        commit;

    assign diff      = i_time_now - r_start;
    assign len       = (diff[47:32] != 16'd0) ? 32'hFFFF_FFFF : diff[31:0];
    assign phase_inc = r_phase + 16'd1;
    assign period    = (r_period == 16'd0) ? 16'd1 : r_period;
    assign sampled   = (phase_inc >= period) || (phase_inc == 16'd0);
    assign commit    = (kls_pkg::t_op'(i_operation) == kls_pkg::OP_COMMIT) && i_sample_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= kls_pkg::PERIOD_RESET;
            r_start  <= 48'd0;
            r_phase  <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (i_accept) begin
                if (kls_pkg::t_op'(i_operation) == kls_pkg::OP_BEGIN) begin
                    r_start <= i_time_now;
                end
                if (commit) begin
                    r_phase <= sampled ? 16'd0 : phase_inc;
                end
            end
        end
    end

    always_comb begin
        o_cmd.id   = i_block_id;
        o_cmd.len  = len;
        o_cmd.kind = kls_pkg::K_DONE;
        if (commit && sampled) begin
            o_cmd.kind = kls_pkg::K_SAMPLE;
        end else if (kls_pkg::t_op'(i_operation) == kls_pkg::OP_QUERY) begin
            o_cmd.kind = kls_pkg::K_QUERY;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kls_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kls_back
// Table of statistics entries with a sequencer that looks up ways, runs the
// Welford update and answers queries.
// ----------------------------------------------------------------------------
module kls_back #(
    parameter int BUCKETS = kls_pkg::BUCKETS_DEF,
    parameter int WAYS    = kls_pkg::WAYS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kls_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_sample_count,
    output logic [47:0]        o_mean_value,
    output logic [63:0]        o_variance_value,
    output logic [31:0]        o_min_length,
    output logic [31:0]        o_max_length
);

    localparam int TBL   = BUCKETS * WAYS;
    localparam int IDX_W = (TBL > 1) ? $clog2(TBL) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // The set index comes from a reciprocal multiplication that is exact for
    // every 16-bit identifier.
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    kls_pkg::t_entry   r_mem [TBL];
    kls_pkg::t_entry   r_rdata;
    kls_pkg::t_entry   r_ent;
    logic [TBL-1:0]    r_valid;
    kls_pkg::t_bstate  r_state;
    kls_pkg::t_bstate  n_state;
    kls_pkg::t_cmd     r_cmd;
    kls_pkg::t_status  r_status;
    logic [15:0]       r_idq;
    logic [IDX_W-1:0]  r_base;
    logic [WAY_W-1:0]  r_way;
    logic [IDX_W-1:0]  r_eaddr;
    logic [IDX_W-1:0]  r_free;
    logic              r_has_free;
    logic              r_show;
    logic [47:0]       r_d1;
    logic [47:0]       r_d2;
    logic              r_pos;
    logic [95:0]       r_acc;
    logic [1:0]        r_mstep;
    logic [63:0]       r_var;
    logic              r_out_valid;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_count;
    logic [47:0]       r_o_mean;
    logic [63:0]       r_o_var;
    logic [31:0]       r_o_min;
    logic [31:0]       r_o_max;

    logic [IDX_W-1:0]  cur_addr;
    logic              hit;
    logic              last_way;
    logic              out_load;
    logic [47:0]       id_prod;
    logic [31:0]       id_rem;
    logic              div_start;
    logic [63:0]       div_dividend;
    logic [31:0]       div_divisor;
    logic              div_done;
    logic [63:0]       div_quot;
    logic [47:0]       x_val;
    logic [47:0]       mean_new;
    logic [23:0]       pa;
    logic [23:0]       pb;
    logic [47:0]       pp;
    logic [95:0]       pp_sh;
    logic [64:0]       m2_sum;
    logic [31:0]       cnt_new;
    logic              upd_pos;

    assign id_prod  = {32'd0, i_cmd.id} * {15'd0, RECIP};
    assign id_rem   = {16'd0, r_cmd.id} - {16'd0, r_idq} * 32'(BUCKETS);
    assign cur_addr = r_base + IDX_W'(r_way);
    assign hit      = r_valid[cur_addr] && (r_rdata.tag == r_cmd.id);
    assign last_way = r_way == WAY_W'(WAYS - 1);
    assign out_load = (r_state == kls_pkg::B_OUT) && (!r_out_valid || i_ready);
    assign x_val    = {r_cmd.len, 16'd0};
    assign cnt_new  = (r_ent.count != kls_pkg::COUNT_MAX) ? r_ent.count + 32'd1 : r_ent.count;
    assign upd_pos  = x_val >= r_ent.mean;
    assign mean_new = r_pos ? r_ent.mean + div_quot[47:0] : r_ent.mean - div_quot[47:0];
    assign m2_sum   = {1'b0, r_ent.m2} + {1'b0, r_acc[95:32]};

    kls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kls_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_cmd.kind == kls_pkg::K_DONE) ? kls_pkg::B_OUT : kls_pkg::B_MOD;
                end
            end
            kls_pkg::B_MOD: begin
                n_state = kls_pkg::B_RD;
            end
            kls_pkg::B_RD: begin
                n_state = kls_pkg::B_CHK;
            end
            kls_pkg::B_CHK: begin
                if (hit) begin
                    if (r_cmd.kind == kls_pkg::K_SAMPLE) begin
                        n_state = kls_pkg::B_UPD;
                    end else if (r_rdata.count <= 32'd1) begin
                        n_state = kls_pkg::B_OUT;
                    end else begin
                        n_state = kls_pkg::B_VAR;
                    end
                end else if (last_way) begin
                    if (r_cmd.kind == kls_pkg::K_SAMPLE &&
                        (r_has_free || !r_valid[cur_addr])) begin
                        n_state = kls_pkg::B_UPD;
                    end else begin
                        n_state = kls_pkg::B_OUT;
                    end
                end else begin
                    n_state = kls_pkg::B_RD;
                end
            end
            kls_pkg::B_UPD: begin
                n_state = kls_pkg::B_MEAN;
            end
            kls_pkg::B_MEAN: begin
                if (div_done) begin
                    n_state = kls_pkg::B_MUL;
                end
            end
            kls_pkg::B_MUL: begin
                if (r_mstep == 2'd3) begin
                    n_state = kls_pkg::B_WR;
                end
            end
            kls_pkg::B_WR: begin
                n_state = kls_pkg::B_OUT;
            end
            kls_pkg::B_VAR: begin
                if (div_done) begin
                    n_state = kls_pkg::B_OUT;
                end
            end
            kls_pkg::B_OUT: begin
                if (out_load) begin
                    n_state = kls_pkg::B_IDLE;
                end
            end
            default: n_state = kls_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = 64'd0;
        div_divisor  = 32'd1;
        unique case (r_state)
            kls_pkg::B_IDLE: begin
                o_pop = !i_empty;
            end
            kls_pkg::B_CHK: begin
                div_start    = hit && (r_cmd.kind == kls_pkg::K_QUERY) &&
                               (r_rdata.count > 32'd1);
                div_dividend = r_rdata.m2;
                div_divisor  = r_rdata.count - 32'd1;
            end
            kls_pkg::B_UPD: begin
                div_start    = 1'b1;
                div_dividend = {16'd0, upd_pos ? x_val - r_ent.mean : r_ent.mean - x_val};
                div_divisor  = cnt_new;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_mstep)
            2'd0:    begin pa = r_d1[23:0];  pb = r_d2[23:0];  end
            2'd1:    begin pa = r_d1[23:0];  pb = r_d2[47:24]; end
            2'd2:    begin pa = r_d1[47:24]; pb = r_d2[23:0];  end
            default: begin pa = r_d1[47:24]; pb = r_d2[47:24]; end
        endcase
        pp = {24'd0, pa} * {24'd0, pb};
        case (r_mstep)
            2'd0:    pp_sh = {48'd0, pp};
            2'd3:    pp_sh = {pp, 48'd0};
            default: pp_sh = {24'd0, pp, 24'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kls_pkg::B_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == kls_pkg::B_WR) begin
                r_valid[r_eaddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kls_pkg::B_RD) begin
            r_rdata <= r_mem[cur_addr];
        end
        if (r_state == kls_pkg::B_WR) begin
            r_mem[r_eaddr] <= '{tag: r_ent.tag, count: r_ent.count, mean: r_ent.mean,
                                m2: m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0],
                                min: r_ent.min, max: r_ent.max};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kls_pkg::B_IDLE: begin
                r_cmd      <= i_cmd;
                r_idq      <= id_prod[47:32];
                r_status   <= kls_pkg::ST_DONE;
                r_show     <= 1'b0;
                r_has_free <= 1'b0;
                r_var      <= 64'd0;
                r_way      <= '0;
            end
            kls_pkg::B_MOD: begin
                r_base <= IDX_W'(id_rem * 32'(WAYS));
            end
            kls_pkg::B_CHK: begin
                if (!r_valid[cur_addr] && !r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= cur_addr;
                end
                if (hit) begin
                    r_ent   <= r_rdata;
                    r_eaddr <= cur_addr;
                    r_show  <= r_cmd.kind == kls_pkg::K_QUERY;
                end else if (last_way) begin
                    r_ent   <= '{tag: r_cmd.id, default: '0};
                    r_eaddr <= r_has_free ? r_free : cur_addr;
                    r_status <= (r_cmd.kind == kls_pkg::K_QUERY) ? kls_pkg::ST_MISSING :
                                kls_pkg::ST_FULL;
                end else begin
                    r_way <= r_way + 1'b1;
                end
            end
            kls_pkg::B_UPD: begin
                r_pos       <= upd_pos;
                r_d1        <= upd_pos ? x_val - r_ent.mean : r_ent.mean - x_val;
                r_ent.count <= cnt_new;
                if (r_ent.count == 32'd0) begin
                    r_ent.min <= r_cmd.len;
                    r_ent.max <= r_cmd.len;
                end else begin
                    if (r_cmd.len < r_ent.min) begin
                        r_ent.min <= r_cmd.len;
                    end
                    if (r_cmd.len > r_ent.max) begin
                        r_ent.max <= r_cmd.len;
                    end
                end
            end
            kls_pkg::B_MEAN: begin
                if (div_done) begin
                    r_ent.mean <= mean_new;
                    r_d2       <= r_pos ? x_val - mean_new : mean_new - x_val;
                    r_acc      <= 96'd0;
                    r_mstep    <= 2'd0;
                end
            end
            kls_pkg::B_MUL: begin
                r_acc   <= r_acc + pp_sh;
                r_mstep <= r_mstep + 2'd1;
            end
            kls_pkg::B_WR: begin
                r_status <= kls_pkg::ST_RECORDED;
            end
            kls_pkg::B_VAR: begin
                if (div_done) begin
                    r_var <= div_quot;
                end
            end
            default: begin
                r_var <= r_var;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_count  <= r_show ? r_ent.count : 32'd0;
            r_o_mean   <= r_show ? r_ent.mean : 48'd0;
            r_o_var    <= r_show ? r_var : 64'd0;
            r_o_min    <= r_show ? r_ent.min : 32'd0;
            r_o_max    <= r_show ? r_ent.max : 32'd0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_sample_count   = r_o_count;
    assign o_mean_value     = r_o_mean;
    assign o_variance_value = r_o_var;
    assign o_min_length     = r_o_min;
    assign o_max_length     = r_o_max;

endmodule
`default_nettype wire

// ----- rtl/keyed_latency_statistics.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_latency_statistics
// Per-identifier latency statistics with a Welford running mean and M2.
//
// Channel   Direction  Handshake                 Words
// input     in         i_valid / o_ready         operation, id, time, valid
// result    out        o_valid / i_ready         status and statistics
// config    in         i_cfg_wr_en               sampling period
//
// A begin or unsampled commit goes straight to the back's output state. A
// sample or query lookup finds the set and then checks the ways in turn; a
// recorded sample runs the 64-step divider for the mean and the multiply for
// M2, and a query variance runs the divider. The front accepts a word
// whenever the four-deep queue has room, and the back holds in its output
// state while a finished result waits. Reset clears the valid bits at once.
// ----------------------------------------------------------------------------
module keyed_latency_statistics #(
    parameter int BUCKETS = kls_pkg::BUCKETS_DEF,
    parameter int WAYS    = kls_pkg::WAYS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [15:0] i_block_id,
    input  wire logic [47:0] i_time_now,
    input  wire logic        i_sample_valid,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_sample_count,
    output logic [47:0]      o_mean_value,
    output logic [63:0]      o_variance_value,
    output logic [31:0]      o_min_length,
    output logic [31:0]      o_max_length
);

    kls_pkg::t_cmd front_cmd;
    kls_pkg::t_cmd head_cmd;
    logic          full;
    logic          empty;
    logic          pop;
    logic          accept;

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    kls_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_block_id     (i_block_id),
        .i_time_now     (i_time_now),
        .i_sample_valid (i_sample_valid),
        .o_cmd          (front_cmd)
    );

    kls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    kls_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_empty          (empty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_sample_count   (o_sample_count),
        .o_mean_value     (o_mean_value),
        .o_variance_value (o_variance_value),
        .o_min_length     (o_min_length),
        .o_max_length     (o_max_length)
    );

    a_zero_unless_found : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != kls_pkg::ST_DONE) |->
            (o_sample_count == 32'd0) && (o_max_length == 32'd0))
        else $error("statistics shown without a found entry");

    a_min_le_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_sample_count != 32'd0) |-> o_min_length <= o_max_length)
        else $error("minimum above maximum");

    a_var_small_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_sample_count <= 32'd1) |-> o_variance_value == 64'd0)
        else $error("variance nonzero for at most one sample");

endmodule
`default_nettype wire

// ----- test/keyed_latency_statistics_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_latency_statistics_tb
// Self-checking bench for the per-identifier latency statistics block.
//
// A queue of words is driven in random bursts while the result side stalls on
// its own pattern. Each accepted word runs through a local model of the
// sampler and the set-associative Welford table, and every result is checked
// field by field against the oldest expected one. The run goes through
// several sampling periods, written only while the block is idle.
// ----------------------------------------------------------------------------
module keyed_latency_statistics_tb;

    localparam int NSETS  = kls_pkg::BUCKETS_DEF;
    localparam int NWAYS  = kls_pkg::WAYS_DEF;
    localparam int NSLOTS = NSETS * NWAYS;

    typedef struct {
        kls_pkg::t_op op;
        logic [15:0]  id;
        logic [47:0]  now;
        logic         sv;
    } t_word;

    typedef struct {
        kls_pkg::t_status status;
        logic [31:0]      count;
        logic [47:0]      mean;
        logic [63:0]      variance;
        logic [31:0]      min_len;
        logic [31:0]      max_len;
    } t_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_op = '0;
    logic [15:0] in_id = '0;
    logic [47:0] in_now = '0;
    logic        in_sv = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_status;
    logic [31:0] out_count;
    logic [47:0] out_mean;
    logic [63:0] out_variance;
    logic [31:0] out_min;
    logic [31:0] out_max;

    t_word  pending_words[$];
    t_stats expected_stats[$];
    int     errors = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_mode = 0;
    int     stall_timer = 0;

    logic [15:0] period_reg = kls_pkg::PERIOD_RESET;
    logic [47:0] start_stamp = '0;
    logic [15:0] phase_cnt = '0;
    logic        slot_valid[NSLOTS];
    logic [15:0] slot_tag[NSLOTS];
    logic [31:0] slot_count[NSLOTS];
    logic [47:0] slot_mean[NSLOTS];
    logic [63:0] slot_m2[NSLOTS];
    logic [31:0] slot_min[NSLOTS];
    logic [31:0] slot_max[NSLOTS];

    logic [15:0] id_pool[24];
    logic [47:0] clock_stamp = '0;

    keyed_latency_statistics DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_operation      (in_op),
        .i_block_id       (in_id),
        .i_time_now       (in_now),
        .i_sample_valid   (in_sv),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_status         (out_status),
        .o_sample_count   (out_count),
        .o_mean_value     (out_mean),
        .o_variance_value (out_variance),
        .o_min_length     (out_min),
        .o_max_length     (out_max)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int find_slot(logic [15:0] id);
        int base;
        base = (id % NSETS) * NWAYS;
        for (int w = 0; w < NWAYS; w++) begin
            if (slot_valid[base + w] && slot_tag[base + w] == id) return base + w;
        end
        return -1;
    endfunction

    function automatic void welford_update(int s, logic [31:0] len);
        logic [63:0]  m, x, d1, d2, mn, term;
        logic [31:0]  n;
        logic [127:0] prod;
        m = {16'd0, slot_mean[s]};
        x = {16'd0, len, 16'd0};
        n = slot_count[s];
        if (n == 0) begin
            slot_min[s] = len;
            slot_max[s] = len;
        end else if (len < slot_min[s]) begin
            slot_min[s] = len;
        end else if (len > slot_max[s]) begin
            slot_max[s] = len;
        end
        if (n != kls_pkg::COUNT_MAX) n = n + 32'd1;
        slot_count[s] = n;
        if (x >= m) begin
            d1 = x - m;
            mn = m + d1 / {32'd0, n};
            d2 = x - mn;
        end else begin
            d1 = m - x;
            mn = m - d1 / {32'd0, n};
            d2 = mn - x;
        end
        slot_mean[s] = mn[47:0];
        prod = {64'd0, d1} * {64'd0, d2};
        term = prod[95:32];
        if (slot_m2[s] > ~64'd0 - term) slot_m2[s] = ~64'd0;
        else slot_m2[s] = slot_m2[s] + term;
    endfunction

    function automatic t_stats predict_stats(t_word w);
        t_stats      r;
        logic [47:0] diff;
        logic [31:0] len;
        logic [15:0] per;
        int          s, base;
        r = '{kls_pkg::ST_DONE, '0, '0, '0, '0, '0};
        if (w.op == kls_pkg::OP_BEGIN) begin
            start_stamp = w.now;
        end else if (w.op == kls_pkg::OP_COMMIT && w.sv) begin
            diff = w.now - start_stamp;
            len = (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
            per = (period_reg == 0) ? 16'd1 : period_reg;
            phase_cnt = phase_cnt + 16'd1;
            if (phase_cnt >= per || phase_cnt == 0) begin
                phase_cnt = '0;
                s = find_slot(w.id);
                if (s < 0) begin
                    base = (w.id % NSETS) * NWAYS;
                    for (int k = 0; k < NWAYS; k++) begin
                        if (s < 0 && !slot_valid[base + k]) begin
                            s = base + k;
                            slot_valid[s] = 1'b1;
                            slot_tag[s] = w.id;
                            slot_count[s] = '0;
                            slot_mean[s] = '0;
                            slot_m2[s] = '0;
                            slot_min[s] = '0;
                            slot_max[s] = '0;
                        end
                    end
                end
                if (s < 0) begin
                    r.status = kls_pkg::ST_FULL;
                end else begin
                    welford_update(s, len);
                    r.status = kls_pkg::ST_RECORDED;
                end
            end
        end else if (w.op == kls_pkg::OP_QUERY) begin
            s = find_slot(w.id);
            if (s < 0) begin
                r.status = kls_pkg::ST_MISSING;
            end else begin
                r.count = slot_count[s];
                r.mean = slot_mean[s];
                r.variance = (slot_count[s] <= 1) ? 64'd0 :
                             slot_m2[s] / {32'd0, slot_count[s] - 32'd1};
                r.min_len = slot_min[s];
                r.max_len = slot_max[s];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                w = '{kls_pkg::t_op'(in_op), in_id, in_now, in_sv};
                expected_stats.push_back(predict_stats(w));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    in_op <= w.op;
                    in_id <= w.id;
                    in_now <= w.now;
                    in_sv <= w.sv;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_stats.size() == 0) begin
                    report_mismatch("unexpected word status", 64'(out_status), 64'd0);
                end else begin
                    e = expected_stats.pop_front();
                    if (out_status != e.status)
                        report_mismatch("status", 64'(out_status), 64'(e.status));
                    if (out_count != e.count)
                        report_mismatch("count", 64'(out_count), 64'(e.count));
                    if (out_mean != e.mean)
                        report_mismatch("mean", 64'(out_mean), 64'(e.mean));
                    if (out_variance != e.variance)
                        report_mismatch("variance", out_variance, e.variance);
                    if (out_min != e.min_len)
                        report_mismatch("min", 64'(out_min), 64'(e.min_len));
                    if (out_max != e.max_len)
                        report_mismatch("max", 64'(out_max), 64'(e.max_len));
                end
            end
            if (stall_timer == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(50, 400);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_stats.size() != 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_period(logic [15:0] value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        period_reg = value;
    endtask

    task automatic add_word(kls_pkg::t_op op, logic [15:0] id, logic [47:0] now, logic sv);
        pending_words.push_back('{op, id, now, sv});
    endtask

    task automatic add_random_words(int count);
        logic [15:0] id;
        logic [47:0] len;
        int          r, made;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            id = id_pool[$urandom_range(0, 23)];
            if ($urandom_range(0, 19) == 0) clock_stamp = 48'({$urandom, $urandom});
            if (r < 70) begin
                add_word(kls_pkg::OP_BEGIN, id, clock_stamp, 1'($urandom_range(0, 1)));
                made++;
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 9))
                        0: len = {16'd0, $urandom};
                        1: len = 48'({$urandom, $urandom});
                        default: len = 48'($urandom_range(0, 5000));
                    endcase
                    clock_stamp = clock_stamp + len;
                    add_word(kls_pkg::OP_COMMIT, id, clock_stamp, $urandom_range(0, 7) != 0);
                    made++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_word(kls_pkg::OP_QUERY, id, 48'({$urandom, $urandom}),
                             1'($urandom_range(0, 1)));
                    made++;
                end
            end else if (r < 85) begin
                add_word(kls_pkg::OP_QUERY, ($urandom_range(0, 3) == 0) ? 16'($urandom) : id,
                         48'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                add_word(kls_pkg::t_op'($urandom_range(0, 3)), 16'($urandom),
                         48'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NSLOTS; k++) begin
            slot_valid[k] = 1'b0;
            slot_tag[k] = '0;
            slot_count[k] = '0;
            slot_mean[k] = '0;
            slot_m2[k] = '0;
            slot_min[k] = '0;
            slot_max[k] = '0;
        end
        for (int k = 0; k < 24; k++) begin
            id_pool[k] = (k < 6) ? 16'(7 + 64 * k * 97) : 16'($urandom);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        add_random_words(40);
        wait_idle();

        set_period(16'd1);
        add_word(kls_pkg::OP_QUERY, 16'd5, 48'd0, 1'b0);
        add_word(kls_pkg::OP_NONE, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_word(kls_pkg::OP_BEGIN, 16'd5, 48'd0, 1'b0);
        add_word(kls_pkg::OP_COMMIT, 16'd5, 48'd100, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd5, 48'd300, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd5, 48'd900, 1'b0);
        add_word(kls_pkg::OP_QUERY, 16'd5, 48'd0, 1'b1);
        add_word(kls_pkg::OP_BEGIN, 16'd0, 48'hFFFF_FFFF_FFF0, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd5, 48'h10, 1'b1);
        add_word(kls_pkg::OP_BEGIN, 16'd0, 48'd0, 1'b0);
        add_word(kls_pkg::OP_COMMIT, 16'd0, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'hFFFF, 48'h1_0000_0000, 1'b1);
        add_word(kls_pkg::OP_QUERY, 16'hFFFF, 48'd0, 1'b0);
        add_word(kls_pkg::OP_QUERY, 16'd5, 48'd0, 1'b0);
        add_word(kls_pkg::OP_BEGIN, 16'd1, 48'd1234, 1'b0);
        add_word(kls_pkg::OP_COMMIT, 16'd1, 48'd1234, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd65, 48'd2000, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd129, 48'd3000, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd193, 48'd4000, 1'b1);
        add_word(kls_pkg::OP_COMMIT, 16'd257, 48'd5000, 1'b1);
        add_word(kls_pkg::OP_QUERY, 16'd257, 48'd0, 1'b0);
        add_word(kls_pkg::OP_COMMIT, 16'd1, 48'd9000, 1'b1);
        add_word(kls_pkg::OP_QUERY, 16'd1, 48'd0, 1'b0);
        wait_idle();

        add_random_words(300);
        wait_idle();
        set_period(16'd3);
        add_random_words(180);
        wait_idle();
        set_period(16'd1);
        add_random_words(250);
        wait_idle();
        set_period(16'hFFFF);
        add_random_words(120);
        wait_idle();
        set_period(16'd2);
        add_random_words(220);
        wait_idle();
        set_period(16'd1);
        add_random_words(220);
        wait_idle();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- keyed_latency_statistics.f -----
rtl/kls_pkg.sv
rtl/kls_div.sv
rtl/kls_fifo.sv
rtl/kls_front.sv
rtl/kls_back.sv
rtl/keyed_latency_statistics.sv
test/keyed_latency_statistics_tb.sv
